// File: hw/rtl/vrbq_pkg.sv
// Shared types and constants for the variable-record byte ring queue.
// Used by the ring store, the top level and the port checker.
package vrbq_pkg;

  // Ring geometry: the ring size must be a power of two.
  localparam int RING_BYTES = 256;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int USED_W     = 9;
  localparam int CNT_W      = 9;

  // Largest record is a command byte and two 32-bit words.
  localparam int REC_BYTES  = 9;
  localparam int STEP_W     = $clog2(REC_BYTES);
  localparam int NEED_W     = 4;

  localparam logic [USED_W-1:0] RING_SIZE = USED_W'(RING_BYTES);
  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

  // Operation codes carried by the func field.
  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_POP  = 2'd1,
    FN_PEEK = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Byte commands from the sequencer to the ring store.
  typedef struct packed {
    logic       wr;
    logic [7:0] wdata;
    logic       rd;
    logic       adv;
  } ring_ctl_t;

endpackage

// File: hw/rtl/vrbq_ring.sv
// Byte-wide ring store with its write and read pointers.
// Depends on vrbq_pkg for the ring size and the control struct.
module vrbq_ring
  import vrbq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ring_ctl_t  ctl,
  output logic [7:0] rdata
);

  logic [7:0]       mem [RING_BYTES];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;

  // Pointers wrap naturally since the ring size is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (ctl.wr) begin
        wp <= wp + 1'b1;
      end
      if (ctl.rd && ctl.adv) begin
        rp <= rp + 1'b1;
      end
    end
  end

  // One write port at the write pointer.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wp] <= ctl.wdata;
    end
  end

  // Registered read at the read pointer.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[rp];
    end
  end

endmodule

// File: hw/rtl/variable_record_byte_ring_queue_core.sv
// Top level of the variable-record byte ring queue: sequencer, counters and result register.
// Depends on vrbq_pkg and instantiates vrbq_ring.
//
// The queue keeps records of 1, 5 or 9 bytes (a command byte and zero, one or two 32-bit
// words, least significant byte first) in a 256-byte ring. One word is handled at a time and
// moves through the ring at one byte per cycle over its single byte-wide memory port. The
// finished result sits in an output register, so the next word is taken while it waits to be
// read. The ring needs no initialization after reset; free_bytes and command_count report the
// state after each word.
module variable_record_byte_ring_queue_core
  import vrbq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [1:0]        payload_words,
  input  logic [7:0]        cmd,
  input  logic [31:0]       word_a,
  input  logic [31:0]       word_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [7:0]        cmd_out,
  output logic [31:0]       word_a_out,
  output logic [31:0]       word_b_out,
  output logic [USED_W-1:0] free_bytes,
  output logic [CNT_W-1:0]  command_count
);

  state_t            state;
  state_t            state_next;
  func_t             op;
  func_t             in_op;
  logic [NEED_W-1:0] need;
  logic              item_ok;
  logic [8:0][7:0]   rec;
  logic [8:0][7:0]   acc;
  logic [STEP_W-1:0] step;
  logic              rd_pend;
  logic [STEP_W-1:0] rd_idx;
  logic [USED_W-1:0] used;
  logic [CNT_W-1:0]  count;
  logic [7:0]        rdata;
  ring_ctl_t         ctl;

  logic [1:0]        in_words;
  logic [NEED_W-1:0] in_need;
  logic [USED_W-1:0] free_now;
  logic              accept;
  logic              accept_ok;
  logic              last_step;
  logic              load_out;
  logic [USED_W-1:0] used_next;
  logic [CNT_W-1:0]  count_next;

  // Decode the incoming word; a word count of three saturates to two.
  always_comb begin
    in_op    = func_t'(func);
    in_words = (payload_words == 2'd3) ? 2'd2 : payload_words;
    in_need  = NEED_W'(1) + {in_words, 2'b00};
    free_now = RING_SIZE - used;
    accept   = in_valid && in_ready;
    case (in_op)
      FN_PUSH: accept_ok = (free_now >= USED_W'(in_need)) && (count != COUNT_MAX);
      FN_POP:  accept_ok = (count != '0) && (used >= USED_W'(in_need));
      FN_PEEK: accept_ok = (count != '0) && (used != '0);
      default: accept_ok = 1'b0;
    endcase
  end

  assign last_step = (NEED_W'(step) == need - NEED_W'(1));
  assign load_out  = (state == S_FINISH) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!accept_ok) begin
            state_next = S_FINISH;
          end else if (in_op == FN_PUSH) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_WRITE: begin
        if (last_step) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        if (op == FN_PEEK || last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and byte commands to the ring.
  always_comb begin
    in_ready  = (state == S_IDLE);
    ctl.wr    = (state == S_WRITE);
    ctl.wdata = rec[0];
    ctl.rd    = (state == S_READ);
    ctl.adv   = (op == FN_POP);
  end

  // Occupancy after the current word completes.
  always_comb begin
    used_next  = used;
    count_next = count;
    if (item_ok) begin
      case (op)
        FN_PUSH: begin
          used_next  = used + USED_W'(need);
          count_next = count + CNT_W'(1);
        end
        FN_POP: begin
          used_next  = used - USED_W'(need);
          count_next = count - CNT_W'(1);
        end
        default: begin
          used_next  = used;
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_READ);
      if (load_out) begin
        used      <= used_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Word registers, byte step counter and read capture.
  always_ff @(posedge clk) begin
    rd_idx <= step;
    if (accept) begin
      op      <= in_op;
      need    <= in_need;
      item_ok <= accept_ok;
      rec     <= {word_b, word_a, cmd};
      acc     <= '0;
      step    <= '0;
    end else begin
      if (state == S_WRITE) begin
        rec  <= {8'h00, rec[8:1]};
        step <= step + STEP_W'(1);
      end
      if (state == S_READ) begin
        step <= step + STEP_W'(1);
      end
      if (rd_pend) begin
        acc[rd_idx] <= rdata;
      end
    end
  end

  // Result register; unread bytes of the capture register stay zero.
  always_ff @(posedge clk) begin
    if (load_out) begin
      ok            <= item_ok;
      cmd_out       <= acc[0];
      word_a_out    <= {acc[4], acc[3], acc[2], acc[1]};
      word_b_out    <= {acc[8], acc[7], acc[6], acc[5]};
      free_bytes    <= RING_SIZE - used_next;
      command_count <= count_next;
    end
  end

  vrbq_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .rdata (rdata)
  );

endmodule

// File: hw/rtl/vrbq_checker.sv
// Port-level checks for the variable-record byte ring queue top level.
// Depends on vrbq_pkg; bound to variable_record_byte_ring_queue_core below.
module vrbq_checker
  import vrbq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              ok,
  input logic [7:0]        cmd_out,
  input logic [31:0]       word_a_out,
  input logic [31:0]       word_b_out,
  input logic [USED_W-1:0] free_bytes,
  input logic [CNT_W-1:0]  command_count
);

  // A stalled result holds its status, command byte and counts.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(cmd_out)
      && $stable(free_bytes) && $stable(command_count))
    else $error("result changed while stalled");

  // Only one word is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // A failed operation returns no data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> cmd_out == 8'h00 && word_a_out == 32'h0 && word_b_out == 32'h0)
    else $error("data returned on failed operation");

  // Free space never exceeds the ring.
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_bytes <= RING_SIZE)
    else $error("free byte count out of range");

endmodule

bind variable_record_byte_ring_queue_core vrbq_checker u_vrbq_checker (.*);
